>>> hw/rtl/apt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants of the affine point transform core.
// ----------------------------------------------------------------------------
package apt_pkg;

   localparam int CELL_BITS      = 32;
   localparam int REG_BITS       = 64;
   localparam int REG_COUNT      = 6;
   localparam int REG_INDEX_BITS = 3;
   localparam int LANE_COUNT     = 3;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_ROW0_COLS01 = 3'd0,
      REG_ROW0_COLS23 = 3'd1,
      REG_ROW1_COLS01 = 3'd2,
      REG_ROW1_COLS23 = 3'd3,
      REG_ROW2_COLS01 = 3'd4,
      REG_ROW2_COLS23 = 3'd5
   } reg_index_type;

   // one matrix row: three scale cells and the translation cell
   typedef struct packed {
      logic signed [CELL_BITS-1:0] tr;
      logic signed [CELL_BITS-1:0] c2;
      logic signed [CELL_BITS-1:0] c1;
      logic signed [CELL_BITS-1:0] c0;
   } row_type;

endpackage

>>> hw/rtl/apt_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_lane
// One matrix row: three registered products, then the shifted sum with
// the translation at full width.
// ----------------------------------------------------------------------------
module apt_lane
   import apt_pkg::*;
#(
   parameter int COORD_BITS    = 32,
   parameter int FRACTION_BITS = 16,
   parameter int SUM_BITS      = 50
) (
   input  logic                         clock,
   input  row_type                      row,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic signed [COORD_BITS-1:0] point_z,
   output logic signed [SUM_BITS-1:0]   lane_sum
);

   localparam int PROD_BITS  = CELL_BITS + COORD_BITS;
   localparam int SHIFT_BITS = PROD_BITS - FRACTION_BITS;

   logic signed [PROD_BITS-1:0] prod_in [3];
   logic signed [PROD_BITS-1:0] prod_ff [3];
   logic signed [CELL_BITS-1:0] trans_ff;
   logic signed [SUM_BITS-1:0]  term    [3];
   logic signed [SUM_BITS-1:0]  trans_ext;
   logic signed [SUM_BITS-1:0]  sum_in;
   logic signed [SUM_BITS-1:0]  sum_ff;

   always_comb begin
      prod_in[0] = PROD_BITS'(row.c0) * PROD_BITS'(point_x);
      prod_in[1] = PROD_BITS'(row.c1) * PROD_BITS'(point_y);
      prod_in[2] = PROD_BITS'(row.c2) * PROD_BITS'(point_z);
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      trans_ff <= row.tr;
   end

   // arithmetic shift: drop the fraction bits, keep the sign
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term[k] = {{(SUM_BITS-SHIFT_BITS){prod_ff[k][PROD_BITS-1]}},
                    prod_ff[k][PROD_BITS-1:FRACTION_BITS]};
      end
      trans_ext = {{(SUM_BITS-CELL_BITS){trans_ff[CELL_BITS-1]}}, trans_ff};
      sum_in    = term[0] + term[1] + term[2] + trans_ext;
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign lane_sum = sum_ff;

endmodule

>>> hw/rtl/apt_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_merge
// Clips each lane sum to the coordinate range, ORs the clip flags and
// registers the result with its strobe.
// ----------------------------------------------------------------------------
module apt_merge
   import apt_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int SUM_BITS   = 50
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         sum_valid,
   input  logic signed [SUM_BITS-1:0]   lane_sum [LANE_COUNT],
   output logic                         out_valid,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic signed [COORD_BITS-1:0] out_z,
   output logic                         out_sat
);

   localparam int HEAD_BITS = SUM_BITS - COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] clip_in [LANE_COUNT];
   logic signed [COORD_BITS-1:0] clip_ff [LANE_COUNT];
   logic [LANE_COUNT-1:0]        over;
   logic [HEAD_BITS-1:0]         head     [LANE_COUNT];
   logic                         valid_ff;
   logic                         sat_ff;

   always_comb begin
      for (int i = 0; i < LANE_COUNT; i++) begin
         head[i] = lane_sum[i][SUM_BITS-1:COORD_BITS-1];
         over[i] = !((&head[i]) || !(|head[i]));
         if (!over[i]) begin
            clip_in[i] = lane_sum[i][COORD_BITS-1:0];
         end else if (lane_sum[i][SUM_BITS-1]) begin
            clip_in[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
         end else begin
            clip_in[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sum_valid;
      end
      clip_ff <= clip_in;
      sat_ff  <= |over;
   end

   assign out_valid = valid_ff;
   assign out_x     = clip_ff[0];
   assign out_y     = clip_ff[1];
   assign out_z     = clip_ff[2];
   assign out_sat   = sat_ff;

endmodule

>>> hw/rtl/affine_point_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_point_transform_core
// Transforms 3D points by a 3x4 affine matrix in signed fixed point.
//
// Input: a point transfers at a rising edge with start high and busy low.
// busy is never raised, so one point can enter every cycle.
// Output: each result holds rsp_valid high for one cycle, after passing the
// input register, product stage, sum stage and clip and merge stage.
// Throughput is one point per cycle; three row lanes with three multipliers
// each run side by side and a merge stage clips the sums and combines the
// clip flags.
// Config: csr_wr_en writes csr_wdata into register csr_index at the edge;
// indexes past the last register are ignored. Write only while no point is
// in flight.
// Reset: synchronous; clears the pipeline valid bits and loads the identity
// matrix. The receiver has no way to stall; results must be taken as shown.
// ----------------------------------------------------------------------------
module affine_point_transform_core
   import apt_pkg::*;
#(
   parameter int COORD_BITS    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic signed [COORD_BITS-1:0] rsp_out_z,
   output logic                         rsp_saturated_flag,
   input  logic                         csr_wr_en,
   input  logic [REG_INDEX_BITS-1:0]    csr_index,
   input  logic [REG_BITS-1:0]          csr_wdata
);

   localparam int PROD_BITS  = CELL_BITS + COORD_BITS;
   localparam int SHIFT_BITS = PROD_BITS - FRACTION_BITS;
   localparam int TERM_BITS  = (SHIFT_BITS > CELL_BITS) ? SHIFT_BITS : CELL_BITS;
   localparam int SUM_BITS   = TERM_BITS + 2;

   localparam logic [REG_BITS-1:0] ONE_LO = REG_BITS'(64'd1 << FRACTION_BITS);
   localparam logic [REG_BITS-1:0] ONE_HI = ONE_LO << CELL_BITS;

   logic [REG_BITS-1:0]          cfg_ff [REG_COUNT];
   row_type                      rows   [LANE_COUNT];
   logic signed [COORD_BITS-1:0] pos_x_ff;
   logic signed [COORD_BITS-1:0] pos_y_ff;
   logic signed [COORD_BITS-1:0] pos_z_ff;
   logic                         acc_valid_in;
   logic                         acc_valid_ff;
   logic                         prod_valid_ff;
   logic                         sum_valid_ff;
   logic signed [SUM_BITS-1:0]   lane_sum [LANE_COUNT];

   assign busy         = 1'b0;
   assign acc_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_ROW0_COLS01] <= ONE_LO;
         cfg_ff[REG_ROW0_COLS23] <= '0;
         cfg_ff[REG_ROW1_COLS01] <= ONE_HI;
         cfg_ff[REG_ROW1_COLS23] <= '0;
         cfg_ff[REG_ROW2_COLS01] <= '0;
         cfg_ff[REG_ROW2_COLS23] <= ONE_LO;
      end else if (csr_wr_en && (csr_index < REG_INDEX_BITS'(REG_COUNT))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < LANE_COUNT; r++) begin
         rows[r].c0 = cfg_ff[2*r][CELL_BITS-1:0];
         rows[r].c1 = cfg_ff[2*r][REG_BITS-1:CELL_BITS];
         rows[r].c2 = cfg_ff[2*r+1][CELL_BITS-1:0];
         rows[r].tr = cfg_ff[2*r+1][REG_BITS-1:CELL_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         acc_valid_ff  <= acc_valid_in;
         prod_valid_ff <= acc_valid_ff;
         sum_valid_ff  <= prod_valid_ff;
      end
      pos_x_ff <= req_pos_x;
      pos_y_ff <= req_pos_y;
      pos_z_ff <= req_pos_z;
   end

   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      apt_lane #(
         .COORD_BITS    (COORD_BITS),
         .FRACTION_BITS (FRACTION_BITS),
         .SUM_BITS      (SUM_BITS)
      ) u_lane (
         .clock    (clock),
         .row      (rows[g]),
         .point_x  (pos_x_ff),
         .point_y  (pos_y_ff),
         .point_z  (pos_z_ff),
         .lane_sum (lane_sum[g])
      );
   end

   apt_merge #(
      .COORD_BITS (COORD_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid_ff),
      .lane_sum  (lane_sum),
      .out_valid (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .out_sat   (rsp_saturated_flag)
   );

endmodule

>>> hw/rtl/apt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks of the affine point transform core: fixed latency and
// consistency of the clip flag.
// ----------------------------------------------------------------------------
module apt_checker #(
   parameter int COORD_BITS = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic signed [COORD_BITS-1:0] rsp_out_x,
   input logic signed [COORD_BITS-1:0] rsp_out_y,
   input logic signed [COORD_BITS-1:0] rsp_out_z,
   input logic                         rsp_saturated_flag
);

   localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

   // every input transfer yields a matching result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("result missing four cycles after input transfer");

   // no result without an earlier input transfer
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result without matching input transfer");

   // a clipped result carries at least one coordinate at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated_flag) |->
         (rsp_out_x == MAXV || rsp_out_x == MINV ||
          rsp_out_y == MAXV || rsp_out_y == MINV ||
          rsp_out_z == MAXV || rsp_out_z == MINV))
      else $error("saturated flag set with no coordinate at a limit");

endmodule

bind affine_point_transform_core apt_checker #(
   .COORD_BITS (COORD_BITS)
) u_apt_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_out_x          (rsp_out_x),
   .rsp_out_y          (rsp_out_y),
   .rsp_out_z          (rsp_out_z),
   .rsp_saturated_flag (rsp_saturated_flag)
);
